// ----- rtl/lwus_pkg.sv -----
// Package of the link wake-up sequencer: codes, register defaults and the check byte.
`default_nettype none
package lwus_pkg;

  // Width of the timing registers of the configuration port.
  localparam int unsigned CfgWidth = 16;
  localparam int unsigned CfgIdxWidth = 3;

  // Default build parameters.
  localparam int unsigned TimerBitsDefault = 16;
  localparam int unsigned ReplyBytesDefault = 2;

  // Register defaults after reset.
  localparam logic [15:0] PulseLengthReset = 16'd80;
  localparam logic [15:0] RecvEnableDelayReset = 16'd500;
  localparam logic [15:0] MessageDelayReset = 16'd132;
  localparam logic [15:0] TimeoutFastReset = 16'd858;
  localparam logic [15:0] TimeoutMidReset = 16'd6864;
  localparam logic [15:0] TimeoutSlowReset = 16'd40000;
  localparam logic [2:0] RetryLimitReset = 3'd3;
  localparam logic [7:0] RequestByteReset = 8'hA2;

  // Seed of the check byte and the message type placed in its top bits.
  localparam logic [7:0] CheckSeed = 8'h52;
  localparam logic [1:0] MsgType = 2'b00;

  // Register indexes of the configuration port.
  typedef enum logic [CfgIdxWidth-1:0] {
    CFG_PULSE_LENGTH = 3'd0,
    CFG_RECV_ENABLE  = 3'd1,
    CFG_MSG_DELAY    = 3'd2,
    CFG_TIMEOUT_FAST = 3'd3,
    CFG_TIMEOUT_MID  = 3'd4,
    CFG_TIMEOUT_SLOW = 3'd5,
    CFG_RETRY_LIMIT  = 3'd6,
    CFG_REQUEST_BYTE = 3'd7
  } cfg_idx_e;

  // Request codes of an input beat.
  typedef enum logic [1:0] {
    REQ_START = 2'd0,
    REQ_TICK  = 2'd1,
    REQ_BYTE  = 2'd2,
    REQ_NOP   = 2'd3
  } req_type_e;

  // Physical line modes.
  typedef enum logic [2:0] {
    MODE_INACTIVE = 3'd0,
    MODE_INPUT    = 3'd1,
    MODE_OUTPUT   = 3'd2,
    MODE_SLOW     = 3'd3,
    MODE_MID      = 3'd4,
    MODE_FAST     = 3'd5
  } phy_mode_e;

  // Sequencer phases.
  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_PULSE   = 3'd1,
    PH_REN     = 3'd2,
    PH_DELAY   = 3'd3,
    PH_RX_FAST = 3'd4,
    PH_RX_MID  = 3'd5,
    PH_RX_SLOW = 3'd6
  } phase_e;

  // Check byte: seeded XOR folded to six bits, message type on top.
  function automatic logic [7:0] check_byte(input logic [7:0] b);
    logic [7:0] c;
    logic [7:0] r;
    c = CheckSeed ^ b;
    r[0] = c[0] ^ c[1];
    r[1] = c[2] ^ c[3];
    r[2] = c[4] ^ c[5];
    r[3] = c[6] ^ c[7];
    r[4] = c[0] ^ c[2] ^ c[4] ^ c[6];
    r[5] = c[1] ^ c[3] ^ c[5] ^ c[7];
    r[7:6] = MsgType;
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/lwus_if.sv -----
// Stream interfaces of the link wake-up sequencer: request beats and result beats.
`default_nettype none
interface lwus_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [7:0] rx_byte;

  modport source (output valid, output req_type, output rx_byte, input ready);
  modport sink (input valid, input req_type, input rx_byte, output ready);
endinterface

interface lwus_out_if;
  logic       valid;
  logic       ready;
  logic       line_drive;
  logic [2:0] phy_mode;
  logic       send_now;
  logic [7:0] send_first;
  logic [7:0] send_check;
  logic       busy_res;
  logic       finished;
  logic       success;
  logic [7:0] reply_first;
  logic [7:0] reply_second;
  logic [2:0] attempts_used;

  modport source (
    output valid, output line_drive, output phy_mode, output send_now,
    output send_first, output send_check, output busy_res, output finished,
    output success, output reply_first, output reply_second, output attempts_used,
    input ready
  );
  modport sink (
    input valid, input line_drive, input phy_mode, input send_now,
    input send_first, input send_check, input busy_res, input finished,
    input success, input reply_first, input reply_second, input attempts_used,
    output ready
  );
endinterface
`default_nettype wire

// ----- rtl/link_wake_up_sequencer_unit.sv -----
// Link wake-up sequencer: timers, retry control and the result register.
//
// The block takes one request beat (start, microsecond tick or received byte) per clock
// cycle and returns exactly one result beat for each, in the cycle after acceptance. The
// state update is a single pass of logic from the phase, timer and counter registers to
// the result register, so a new beat is accepted in every cycle in which the result
// register is empty or its beat is taken in the same cycle; only a stalled result
// holds off the input. There is no clearing pass after reset. Configuration writes
// are registered and must be made while no beat is in flight.
`default_nettype none
module link_wake_up_sequencer_unit #(
  parameter int unsigned TIMER_BITS  = lwus_pkg::TimerBitsDefault,
  parameter int unsigned REPLY_BYTES = lwus_pkg::ReplyBytesDefault
) (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 cfg_we_i,
  input  wire  [lwus_pkg::CfgIdxWidth-1:0]    cfg_idx_i,
  input  wire  [lwus_pkg::CfgWidth-1:0]       cfg_wdata_i,
  lwus_in_if.sink                             req_i,
  lwus_out_if.source                          res_o
);
  import lwus_pkg::*;

  localparam logic [1:0] ReplyLast = 2'(REPLY_BYTES);

  // Configuration registers.
  logic [15:0] pulse_len_q, recv_en_q, msg_delay_q;
  logic [15:0] to_fast_q, to_mid_q, to_slow_q;
  logic [2:0]  retry_limit_q;
  logic [7:0]  request_byte_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pulse_len_q    <= PulseLengthReset;
      recv_en_q      <= RecvEnableDelayReset;
      msg_delay_q    <= MessageDelayReset;
      to_fast_q      <= TimeoutFastReset;
      to_mid_q       <= TimeoutMidReset;
      to_slow_q      <= TimeoutSlowReset;
      retry_limit_q  <= RetryLimitReset;
      request_byte_q <= RequestByteReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_PULSE_LENGTH: pulse_len_q    <= cfg_wdata_i;
        CFG_RECV_ENABLE:  recv_en_q      <= cfg_wdata_i;
        CFG_MSG_DELAY:    msg_delay_q    <= cfg_wdata_i;
        CFG_TIMEOUT_FAST: to_fast_q      <= cfg_wdata_i;
        CFG_TIMEOUT_MID:  to_mid_q       <= cfg_wdata_i;
        CFG_TIMEOUT_SLOW: to_slow_q      <= cfg_wdata_i;
        CFG_RETRY_LIMIT:  retry_limit_q  <= cfg_wdata_i[2:0];
        CFG_REQUEST_BYTE: request_byte_q <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  // Sequencer state.
  phase_e                phase_q, phase_d;
  logic [TIMER_BITS-1:0] count_q, count_d;
  logic                  line_q, line_d;
  logic [2:0]            mode_q, mode_d;
  logic [2:0]            attempt_q, attempt_d;
  logic [1:0]            rcnt_q, rcnt_d;
  logic [7:0]            store0_q, store0_d, store1_q, store1_d;
  logic                  outcome_q, outcome_d;

  logic out_valid_q;
  logic in_fire;
  logic send, fin, expire;
  logic [2:0] attempt_inc;

  assign req_i.ready = !out_valid_q || res_o.ready;
  assign in_fire     = req_i.valid && req_i.ready;
  assign attempt_inc = attempt_q + 3'd1;
  assign expire      = (count_q <= TIMER_BITS'(1));

  // Next state for the accepted beat.
  always_comb begin
    phase_d   = phase_q;
    count_d   = count_q;
    line_d    = line_q;
    mode_d    = mode_q;
    attempt_d = attempt_q;
    rcnt_d    = rcnt_q;
    store0_d  = store0_q;
    store1_d  = store1_q;
    outcome_d = outcome_q;
    send      = 1'b0;
    fin       = 1'b0;
    if (in_fire) begin
      case (req_type_e'(req_i.req_type))
        REQ_START: begin
          if (phase_q == PH_IDLE) begin
            attempt_d = 3'd0;
            outcome_d = 1'b0;
            mode_d    = MODE_OUTPUT;
            if (line_q) begin
              line_d  = 1'b0;
              count_d = TIMER_BITS'(msg_delay_q);
              phase_d = PH_DELAY;
            end else begin
              line_d  = 1'b1;
              count_d = TIMER_BITS'(pulse_len_q);
              phase_d = PH_PULSE;
            end
          end
        end
        REQ_TICK: begin
          if (phase_q != PH_IDLE) begin
            count_d = expire ? '0 : count_q - TIMER_BITS'(1);
            if (expire) begin
              case (phase_q)
                PH_PULSE: begin
                  line_d  = 1'b0;
                  count_d = TIMER_BITS'(recv_en_q);
                  phase_d = PH_REN;
                end
                PH_REN: begin
                  count_d = TIMER_BITS'(msg_delay_q);
                  phase_d = PH_DELAY;
                end
                PH_DELAY: begin
                  mode_d  = MODE_FAST;
                  send    = 1'b1;
                  rcnt_d  = 2'd0;
                  count_d = TIMER_BITS'(to_fast_q);
                  phase_d = PH_RX_FAST;
                end
                PH_RX_FAST: begin
                  mode_d  = MODE_MID;
                  send    = 1'b1;
                  rcnt_d  = 2'd0;
                  count_d = TIMER_BITS'(to_mid_q);
                  phase_d = PH_RX_MID;
                end
                PH_RX_MID: begin
                  mode_d  = MODE_SLOW;
                  send    = 1'b1;
                  rcnt_d  = 2'd0;
                  count_d = TIMER_BITS'(to_slow_q);
                  phase_d = PH_RX_SLOW;
                end
                default: begin
                  // Slowest reply wait ran out: retry the whole attempt or give up.
                  attempt_d = attempt_inc;
                  if (attempt_inc < retry_limit_q) begin
                    mode_d = MODE_OUTPUT;
                    if (line_q) begin
                      line_d  = 1'b0;
                      count_d = TIMER_BITS'(msg_delay_q);
                      phase_d = PH_DELAY;
                    end else begin
                      line_d  = 1'b1;
                      count_d = TIMER_BITS'(pulse_len_q);
                      phase_d = PH_PULSE;
                    end
                  end else begin
                    phase_d   = PH_IDLE;
                    outcome_d = 1'b0;
                    fin       = 1'b1;
                  end
                end
              endcase
            end
          end
        end
        REQ_BYTE: begin
          if (phase_q == PH_RX_FAST || phase_q == PH_RX_MID || phase_q == PH_RX_SLOW) begin
            if (rcnt_q == 2'd0) begin
              store0_d = req_i.rx_byte;
            end
            if (rcnt_q == 2'd1) begin
              store1_d = req_i.rx_byte;
            end
            rcnt_d = rcnt_q + 2'd1;
            if (rcnt_d >= ReplyLast) begin
              phase_d   = PH_IDLE;
              outcome_d = 1'b1;
              fin       = 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      count_q   <= '0;
      line_q    <= 1'b0;
      mode_q    <= MODE_INACTIVE;
      attempt_q <= 3'd0;
      rcnt_q    <= 2'd0;
      store0_q  <= 8'd0;
      store1_q  <= 8'd0;
      outcome_q <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      count_q   <= count_d;
      line_q    <= line_d;
      mode_q    <= mode_d;
      attempt_q <= attempt_d;
      rcnt_q    <= rcnt_d;
      store0_q  <= store0_d;
      store1_q  <= store1_d;
      outcome_q <= outcome_d;
    end
  end

  // Result register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (req_i.ready) begin
      out_valid_q <= in_fire;
    end
  end

  // Result payload, loaded with each accepted beat.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      res_o.line_drive    <= line_d;
      res_o.phy_mode      <= mode_d;
      res_o.send_now      <= send;
      res_o.send_first    <= send ? request_byte_q : 8'd0;
      res_o.send_check    <= send ? check_byte(request_byte_q) : 8'd0;
      res_o.busy_res      <= (phase_d != PH_IDLE);
      res_o.finished      <= fin;
      res_o.success       <= outcome_d;
      res_o.reply_first   <= store0_d;
      res_o.reply_second  <= store1_d;
      res_o.attempts_used <= attempt_d;
    end
  end

  assign res_o.valid = out_valid_q;

endmodule
`default_nettype wire

// ----- rtl/lwus_checker.sv -----
// Port checker of the link wake-up sequencer and its bind to the top level.
`default_nettype none
module lwus_checker (
  input wire       clk_i,
  input wire       rst_ni,
  input wire       out_valid_i,
  input wire       out_ready_i,
  input wire       line_drive_i,
  input wire [2:0] phy_mode_i,
  input wire       send_now_i,
  input wire [7:0] send_first_i,
  input wire [7:0] send_check_i,
  input wire       busy_res_i,
  input wire       finished_i
);
  import lwus_pkg::*;

  // A stalled result beat holds its payload.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(send_first_i)
      && $stable(send_check_i) && $stable(finished_i))
    else $error("stalled result beat changed");

  // Message bytes are zero unless a message goes out.
  a_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !send_now_i |-> send_first_i == 8'd0 && send_check_i == 8'd0)
    else $error("message bytes without a send");

  // The check byte matches the request byte that is sent.
  a_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && send_now_i |-> send_check_i == check_byte(send_first_i))
    else $error("check byte mismatch");

  // A send happens mid-sequence, in a baud mode, with the line released.
  a_send: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && send_now_i |-> busy_res_i && !line_drive_i && !finished_i
      && (phy_mode_i == MODE_FAST || phy_mode_i == MODE_MID || phy_mode_i == MODE_SLOW))
    else $error("send outside a reply wait");

  // The beat that ends a sequence leaves the block idle.
  a_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && finished_i |-> !busy_res_i)
    else $error("finished while busy");

endmodule

bind link_wake_up_sequencer_unit lwus_checker u_lwus_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_i  (res_o.valid),
  .out_ready_i  (res_o.ready),
  .line_drive_i (res_o.line_drive),
  .phy_mode_i   (res_o.phy_mode),
  .send_now_i   (res_o.send_now),
  .send_first_i (res_o.send_first),
  .send_check_i (res_o.send_check),
  .busy_res_i   (res_o.busy_res),
  .finished_i   (res_o.finished)
);
`default_nettype wire

// ----- dv/lwus_wake_check.sv -----
`timescale 1ns / 100ps
// Predictor and result comparison for the link wake-up sequencer.
module lwus_wake_check (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [lwus_pkg::CfgIdxWidth-1:0] cfg_idx_i,
  input  logic [lwus_pkg::CfgWidth-1:0]    cfg_wdata_i,
  lwus_in_if                               req_if,
  lwus_out_if                              res_if,
  output logic                             wake_busy_o,
  output int unsigned                      pending_o,
  output int unsigned                      fail_count_o
);
  import lwus_pkg::*;

  localparam int unsigned ReplyBytes = ReplyBytesDefault;

  typedef struct packed {
    logic       line_drive;
    phy_mode_e  phy_mode;
    logic       send_now;
    logic [7:0] send_first;
    logic [7:0] send_check;
    logic       busy_res;
    logic       finished;
    logic       success;
    logic [7:0] reply_first;
    logic [7:0] reply_second;
    logic [2:0] attempts_used;
  } wake_status_t;

  // Copy of the register file.
  logic [15:0] pulse_len_q, ren_delay_q, msg_delay_q;
  logic [15:0] tmo_fast_q, tmo_mid_q, tmo_slow_q;
  logic [2:0]  retry_max_q;
  logic [7:0]  req_byte_q;

  // Copy of the sequencer state.
  phase_e      phase_q;
  logic [15:0] timer_q;
  logic        line_q;
  phy_mode_e   mode_q;
  logic [2:0]  tries_q;
  logic [1:0]  rx_count_q;
  logic [7:0]  replies_q [2];
  logic        won_q;

  wake_status_t awaited_status [$];
  int unsigned  mismatches;

  // Seeded XOR, folded pairwise into bits 3:0 and by parity of even and odd bits into 5:4.
  function automatic logic [7:0] fold_check(logic [7:0] b);
    logic [7:0] c;
    c = b ^ 8'h52;
    return {2'b00, ^(c & 8'hAA), ^(c & 8'h55), ^c[7:6], ^c[5:4], ^c[3:2], ^c[1:0]};
  endfunction

  // A running timer expires on the tick that takes it to zero; zero acts as one.
  function automatic logic timer_expires();
    if (timer_q <= 16'd1) begin
      timer_q = '0;
      return 1'b1;
    end
    timer_q = timer_q - 16'd1;
    return 1'b0;
  endfunction

  // An attempt starts with the wake-up pulse unless the line is already high.
  function automatic void begin_attempt();
    mode_q = MODE_OUTPUT;
    if (line_q) begin
      line_q  = 1'b0;
      timer_q = msg_delay_q;
      phase_q = PH_DELAY;
    end else begin
      line_q  = 1'b1;
      timer_q = pulse_len_q;
      phase_q = PH_PULSE;
    end
  endfunction

  function automatic void open_reply_window(phy_mode_e mode, phase_e next, logic [15:0] tmo);
    mode_q     = mode;
    rx_count_q = '0;
    timer_q    = tmo;
    phase_q    = next;
  endfunction

  function automatic void write_reg(logic [2:0] idx, logic [15:0] data);
    case (cfg_idx_e'(idx))
      CFG_PULSE_LENGTH: pulse_len_q = data;
      CFG_RECV_ENABLE:  ren_delay_q = data;
      CFG_MSG_DELAY:    msg_delay_q = data;
      CFG_TIMEOUT_FAST: tmo_fast_q = data;
      CFG_TIMEOUT_MID:  tmo_mid_q = data;
      CFG_TIMEOUT_SLOW: tmo_slow_q = data;
      CFG_RETRY_LIMIT:  retry_max_q = data[2:0];
      default:          req_byte_q = data[7:0];
    endcase
  endfunction

  // Advances the state by one request beat and returns the status beat it causes.
  function automatic wake_status_t step_sequencer(req_type_e req, logic [7:0] data);
    wake_status_t s;
    logic sent, done;
    sent = 1'b0;
    done = 1'b0;
    case (req)
      REQ_START: begin
        if (phase_q == PH_IDLE) begin
          tries_q = '0;
          won_q   = 1'b0;
          begin_attempt();
        end
      end
      REQ_TICK: begin
        if (phase_q != PH_IDLE && timer_expires()) begin
          case (phase_q)
            PH_PULSE: begin
              line_q  = 1'b0;
              timer_q = ren_delay_q;
              phase_q = PH_REN;
            end
            PH_REN: begin
              timer_q = msg_delay_q;
              phase_q = PH_DELAY;
            end
            PH_DELAY: begin
              open_reply_window(MODE_FAST, PH_RX_FAST, tmo_fast_q);
              sent = 1'b1;
            end
            PH_RX_FAST: begin
              open_reply_window(MODE_MID, PH_RX_MID, tmo_mid_q);
              sent = 1'b1;
            end
            PH_RX_MID: begin
              open_reply_window(MODE_SLOW, PH_RX_SLOW, tmo_slow_q);
              sent = 1'b1;
            end
            default: begin
              // The slowest window timed out: the attempt failed.
              tries_q = tries_q + 3'd1;
              if (tries_q < retry_max_q) begin
                begin_attempt();
              end else begin
                phase_q = PH_IDLE;
                won_q   = 1'b0;
                done    = 1'b1;
              end
            end
          endcase
        end
      end
      REQ_BYTE: begin
        if (phase_q inside {PH_RX_FAST, PH_RX_MID, PH_RX_SLOW}) begin
          if (rx_count_q < ReplyBytes) replies_q[rx_count_q[0]] = data;
          rx_count_q = rx_count_q + 2'd1;
          if (rx_count_q >= ReplyBytes) begin
            phase_q = PH_IDLE;
            won_q   = 1'b1;
            done    = 1'b1;
          end
        end
      end
      default: ;
    endcase
    s.line_drive    = line_q;
    s.phy_mode      = mode_q;
    s.send_now      = sent;
    s.send_first    = sent ? req_byte_q : 8'h00;
    s.send_check    = sent ? fold_check(req_byte_q) : 8'h00;
    s.busy_res      = (phase_q != PH_IDLE);
    s.finished      = done;
    s.success       = won_q;
    s.reply_first   = replies_q[0];
    s.reply_second  = replies_q[1];
    s.attempts_used = tries_q;
    return s;
  endfunction

  function automatic void match_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // Results are compared before the new request is predicted, so a result can never
  // be matched against the request accepted at the same edge.
  always @(posedge clk_i or negedge rst_ni) begin
    wake_status_t want;
    if (!rst_ni) begin
      pulse_len_q  = 16'd80;
      ren_delay_q  = 16'd500;
      msg_delay_q  = 16'd132;
      tmo_fast_q   = 16'd858;
      tmo_mid_q    = 16'd6864;
      tmo_slow_q   = 16'd40000;
      retry_max_q  = 3'd3;
      req_byte_q   = 8'hA2;
      phase_q      = PH_IDLE;
      timer_q      = '0;
      line_q       = 1'b0;
      mode_q       = MODE_INACTIVE;
      tries_q      = '0;
      rx_count_q   = '0;
      replies_q[0] = '0;
      replies_q[1] = '0;
      won_q        = 1'b0;
      awaited_status.delete();
      mismatches   = 0;
      wake_busy_o  <= 1'b0;
      pending_o    <= 0;
      fail_count_o <= 0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        if (awaited_status.size() == 0) begin
          $error("result beat with no request outstanding");
          mismatches++;
        end else begin
          want = awaited_status.pop_front();
          match_field("line_drive", want.line_drive, res_if.line_drive);
          match_field("phy_mode", want.phy_mode, res_if.phy_mode);
          match_field("send_now", want.send_now, res_if.send_now);
          match_field("send_first", want.send_first, res_if.send_first);
          match_field("send_check", want.send_check, res_if.send_check);
          match_field("busy_res", want.busy_res, res_if.busy_res);
          match_field("finished", want.finished, res_if.finished);
          match_field("success", want.success, res_if.success);
          match_field("reply_first", want.reply_first, res_if.reply_first);
          match_field("reply_second", want.reply_second, res_if.reply_second);
          match_field("attempts_used", want.attempts_used, res_if.attempts_used);
        end
      end
      if (cfg_we_i) write_reg(cfg_idx_i, cfg_wdata_i);
      if (req_if.valid && req_if.ready) begin
        awaited_status.push_back(step_sequencer(req_type_e'(req_if.req_type), req_if.rx_byte));
      end
      wake_busy_o  <= (phase_q != PH_IDLE);
      pending_o    <= awaited_status.size();
      fail_count_o <= mismatches;
    end
  end

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 100ps
// Top of the wake-up sequencer test: clock, reset, request stimulus and the verdict.
module tb;
  import lwus_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  cfg_idx_e    cfg_idx_i;
  logic [15:0] cfg_wdata_i;

  lwus_in_if  req_if ();
  lwus_out_if res_if ();

  logic        wake_busy;
  int unsigned pending;
  int unsigned fail_count;

  // Pacing in percent of cycles in which each side holds off.
  int send_gap_pct = 0;
  int recv_gap_pct = 0;

  int unsigned beats = 0;
  int unsigned wake_runs = 0;
  int unsigned plans = 0;
  int unsigned run_beats = 0;
  logic [15:0] plan [8];

  link_wake_up_sequencer_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_if),
    .res_o       (res_if)
  );

  lwus_wake_check u_wake_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .req_if       (req_if),
    .res_if       (res_if),
    .wake_busy_o  (wake_busy),
    .pending_o    (pending),
    .fail_count_o (fail_count)
  );

  always #10 clk_i = ~clk_i;

  // Result side: random stalls at the current rate.
  initial begin
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      res_if.ready <= ($urandom_range(99) >= recv_gap_pct);
    end
  end

  // Presents one request beat, after random gaps, and returns at the edge that takes it.
  task automatic send_beat(req_type_e req, logic [7:0] data);
    while ($urandom_range(99) < send_gap_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid    <= 1'b1;
    req_if.req_type <= req;
    req_if.rx_byte  <= data;
    do @(posedge clk_i); while (!req_if.ready);
    beats++;
  endtask

  // Holds off requests until every predicted result has come back.
  task automatic wait_results_done();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic write_plan();
    for (int i = 0; i < 8; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= cfg_idx_e'(i);
      cfg_wdata_i <= plan[i];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    plans++;
  endtask

  // Short timers, mostly zero to three ticks; retry limit and request byte take
  // the full write data so that the upper bits are exercised as well.
  function automatic void pick_short_plan();
    for (int i = 0; i < 6; i++) begin
      plan[i] = ($urandom_range(7) == 0) ? 16'($urandom_range(12, 4)) : 16'($urandom_range(3));
    end
    plan[CFG_RETRY_LIMIT]  = 16'($urandom);
    plan[CFG_REQUEST_BYTE] = 16'($urandom);
  endfunction

  // One wake-up sequence: a start, then ticks and reply bytes with a little noise,
  // until the sequence has ended. The byte rate is per ten thousand beats.
  task automatic run_wake_up(int unsigned byte_rate);
    int unsigned n;
    int unsigned pick;
    send_beat(REQ_START, 8'($urandom));
    n = 0;
    do begin
      pick = $urandom_range(99);
      if (pick < 2) send_beat(REQ_START, 8'($urandom));
      else if (pick < 4) send_beat(REQ_NOP, 8'($urandom));
      else if ($urandom_range(9999) < byte_rate) send_beat(REQ_BYTE, 8'($urandom));
      else send_beat(REQ_TICK, 8'($urandom));
      n++;
    end while (wake_busy && n < 200000);
    wake_runs++;
    run_beats += n + 1;
  endtask

  initial begin
    int unsigned stage_start;
    int unsigned rate;
    req_if.valid    <= 1'b0;
    req_if.req_type <= REQ_NOP;
    req_if.rx_byte  <= 8'h00;
    cfg_we_i        <= 1'b0;
    cfg_idx_i       <= CFG_PULSE_LENGTH;
    cfg_wdata_i     <= 16'h0000;
    rst_ni          <= 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int stage = 0; stage < 3; stage++) begin
      case (stage)
        0: begin
          send_gap_pct = 9;
          recv_gap_pct = 56;
        end
        1: begin
          send_gap_pct = 56;
          recv_gap_pct = 9;
        end
        default: begin
          send_gap_pct = 0;
          recv_gap_pct = 0;
        end
      endcase

      if (stage == 0) begin
        // Requests that an idle sequencer ignores.
        send_beat(REQ_TICK, 8'h00);
        send_beat(REQ_BYTE, 8'h00);
        send_beat(REQ_NOP, 8'hFF);
        send_beat(REQ_BYTE, 8'hFF);
        // Start on the register defaults, then shorten the timers mid-pulse; the
        // running pulse keeps its default length.
        send_beat(REQ_START, 8'h00);
        repeat (40) send_beat(REQ_TICK, 8'h00);
        wait_results_done();
        pick_short_plan();
        write_plan();
        run_wake_up(300);
        wait_results_done();

        // All timers zero, retry limit zero through a masked write, request byte zero.
        plan = '{default: 16'h0000};
        plan[CFG_RETRY_LIMIT] = 16'hFFF8;
        write_plan();
        send_beat(REQ_START, 8'h00);
        send_beat(REQ_START, 8'hFF);
        send_beat(REQ_BYTE, 8'h5A);
        repeat (3) send_beat(REQ_TICK, 8'h00);
        send_beat(REQ_BYTE, 8'hFF);
        repeat (3) send_beat(REQ_TICK, 8'hFF);
        send_beat(REQ_TICK, 8'h00);
        // A reply of two bytes in the fast window.
        send_beat(REQ_START, 8'h00);
        repeat (3) send_beat(REQ_TICK, 8'h00);
        send_beat(REQ_BYTE, 8'hFF);
        send_beat(REQ_BYTE, 8'h00);
        wait_results_done();
        pick_short_plan();
      end else if (stage == 1) begin
        // Smallest legal timers and a single attempt.
        wait_results_done();
        plan = '{default: 16'h0001};
        plan[CFG_REQUEST_BYTE] = 16'($urandom);
      end else begin
        wait_results_done();
        pick_short_plan();
      end
      write_plan();

      stage_start = run_beats;
      while (run_beats - stage_start < 280) begin
        if ($urandom_range(3) == 0) begin
          wait_results_done();
          pick_short_plan();
          write_plan();
        end
        case ($urandom_range(3))
          0: rate = 0;
          1: rate = 300;
          2: rate = 1500;
          default: rate = 4000;
        endcase
        run_wake_up(rate);
        repeat ($urandom_range(2)) send_beat(req_type_e'($urandom_range(3)), 8'($urandom));
        if ($urandom_range(9) == 0) wait_results_done();
      end

      if (stage == 2) begin
        // Largest reply windows after the shortest lead-in; replies land mid-window.
        wait_results_done();
        plan = '{default: 16'hFFFF};
        plan[CFG_PULSE_LENGTH] = 16'h0001;
        plan[CFG_RECV_ENABLE]  = 16'h0001;
        plan[CFG_MSG_DELAY]    = 16'h0001;
        write_plan();
        run_wake_up(1500);
      end
    end

    wait_results_done();
    repeat (4) @(posedge clk_i);
    $display("Covered %0d request beats in %0d wake-up sequences under %0d register settings,",
             beats, wake_runs, plans);
    $display("with zero, minimum and maximum timers, retry limits 0 to 7 and three pacing modes.");
    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog far beyond the slowest passing run.
  initial begin
    #20000000;
    $display("Timeout: results still outstanding");
    $display("Test completed with failures");
    $finish;
  end

endmodule
